>>> rtl/gblur_pkg.sv
// Shared types and constants for the 5x5 Gaussian blur unit.
`default_nettype none

package gblur_pkg;

	// Window geometry and kernel.
	localparam int TAPS         = 5;
	localparam int KERNEL_TOTAL = 273;
	localparam int WEIGHT_BITS  = 6;

	// Fixed port widths.
	localparam int PORT_PIXEL_BITS   = 8;
	localparam int FRAME_WIDTH_BITS  = 11;
	localparam int FRAME_HEIGHT_BITS = 13;
	localparam int CFG_DATA_BITS     = 13;
	localparam int CFG_INDEX_BITS    = 1;

	// Frame geometry limits and reset values.
	localparam int ROW_BITS     = 13;
	localparam int MAX_HEIGHT   = 4096;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// The line store keeps the four rows above the incoming pixel.
	localparam int LINE_LANES = 4;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef weight_t [TAPS-1:0] weight_col_t;
	typedef weight_col_t [TAPS-1:0] weight_grid_t;

	// Kernel weights, indexed [column][row]; the kernel is symmetric.
	localparam weight_grid_t TAP_WEIGHT = '{
		'{6'd1, 6'd4,  6'd6,  6'd4,  6'd1},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd6, 6'd26, 6'd41, 6'd26, 6'd6},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd1, 6'd4,  6'd6,  6'd4,  6'd1}
	};

	// Which window taps lie inside the frame for one result.
	typedef struct packed {
		logic [TAPS-1:0] row_ok;
		logic [TAPS-1:0] col_ok;
	} tap_mask_t;

	// Per-cell control: column shift, partial sum enable and tap validity.
	typedef struct packed {
		logic            shift;
		logic            calc;
		logic [TAPS-1:0] row_ok;
		logic            col_ok;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/gaussian_blur_5x5_unit.sv
// Top level of the streaming 5x5 Gaussian blur unit.
`default_nettype none

// Filters one frame of pixels given in raster order with a 5x5 Gaussian kernel whose weights
// sum to 269, dividing by 273, dropping taps outside the frame and truncating the quotient.
// The unit takes one pixel per clock while in_stall is low: the line store is a single
// four-lane memory of MAX_WIDTH words with one read and one write each cycle, and the window
// is a row of five column cells that shift once per input transaction. The result for pixel
// k comes out with the input transaction of item k + 2*W + 2; after the last pixel of a
// frame, send 2*W + 2 items with drain set to flush the remaining results. The last result
// of a frame carries frame_end, and the next item starts a new frame. An output register
// plus a one-entry skid buffer decouple the two channels; in_stall rises only while the skid
// buffer holds a result. Any configuration write restarts the frame; widths of zero act as
// one and values above the limits are clamped. No clearing pass follows reset.
module gaussian_blur_5x5_unit
	import gblur_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration port
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data,
	// Input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [PORT_PIXEL_BITS-1:0] pixel_value,
	input  logic                       drain,
	// Output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [PORT_PIXEL_BITS-1:0] blurred_value,
	output logic                       frame_end
);

	localparam int ColBits   = $clog2(MAX_WIDTH);
	localparam int WcntBits  = $clog2(MAX_WIDTH + 1);
	localparam int ColXBits  = WcntBits + 1;
	localparam int LeadBits  = $clog2(2 * MAX_WIDTH + 3);
	localparam int PartBits  = PIXEL_BITS + 7;
	localparam int SumBits   = PIXEL_BITS + 9;
	localparam int LaneBits  = LINE_LANES * PIXEL_BITS;
	localparam int ResetW    = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	// Configuration and frame position state.
	logic [WcntBits-1:0]   eff_w_q;
	logic [ROW_BITS-1:0]   eff_h_q;
	logic [ColBits-1:0]    in_col_q;
	logic [LeadBits-1:0]   lead_q;
	logic [ColBits-1:0]    out_col_q;
	logic [ROW_BITS-1:0]   out_row_q;

	logic [CFG_DATA_BITS-1:0] cfg_w_raw;
	logic [WcntBits-1:0]      cfg_w_eff;
	logic [ROW_BITS-1:0]      cfg_h_eff;

	logic                  in_accept;
	logic                  adv;
	logic [LeadBits-1:0]   lag;
	logic                  res_now;
	logic                  last_now;
	logic                  in_wrap;
	logic                  out_wrap;
	logic [ColXBits-1:0]   col_x;
	logic [ColXBits-1:0]   w_x;
	tap_mask_t             mask_now;
	logic [PIXEL_BITS-1:0] px_now;

	// Pipeline registers.
	logic                  v_s1;
	logic                  res_s1;
	logic                  last_s1;
	tap_mask_t             mask_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [ColBits-1:0]    col_s1;
	logic                  rv_s2;
	logic                  last_s2;
	tap_mask_t             mask_s2;
	logic                  rv_s3;
	logic                  last_s3;
	logic                  rv_s4;
	logic                  last_s4;
	logic [SumBits-1:0]    sum_s4;
	logic [SumBits-1:0]    sum_d;
	logic                  rv_s5;
	logic                  last_s5;
	logic                  rv_s6;
	logic                  last_s6;
	logic [PIXEL_BITS-1:0] quot_s6;

	// Line store and read bypass.
	logic                                   ram_we;
	logic [LINE_LANES-1:0][PIXEL_BITS-1:0]  ram_wdata;
	logic [LINE_LANES-1:0][PIXEL_BITS-1:0]  rd_lanes;
	logic [LINE_LANES-1:0][PIXEL_BITS-1:0]  lanes;
	logic                                   byp_q;
	logic [LINE_LANES-1:0][PIXEL_BITS-1:0]  byp_data_q;

	// Window cells.
	logic [TAPS-1:0][TAPS-1:0][PIXEL_BITS-1:0] win;
	logic [TAPS-1:0][PIXEL_BITS-1:0]           col_new;
	logic [TAPS-1:0][PartBits-1:0]             part;
	cell_ctl_t                                 cell_ctl [TAPS];

	// Output register and skid buffer.
	logic                       out_valid_q;
	logic [PORT_PIXEL_BITS-1:0] out_value_q;
	logic                       out_end_q;
	logic                       skid_valid_q;
	logic [PORT_PIXEL_BITS-1:0] skid_value_q;
	logic                       skid_end_q;
	logic                       out_take;
	logic                       load_out;
	logic                       load_skid;

	// The whole pipeline moves unless the skid buffer is holding a result.
	assign adv       = !skid_valid_q;
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !in_stall;

	// Clamp configuration values to the supported range.
	always_comb begin
		cfg_w_raw = CFG_DATA_BITS'(cfg_data[FRAME_WIDTH_BITS-1:0]);
		if (cfg_w_raw == '0) begin
			cfg_w_eff = WcntBits'(1);
		end else if (cfg_w_raw > CFG_DATA_BITS'(MAX_WIDTH)) begin
			cfg_w_eff = WcntBits'(MAX_WIDTH);
		end else begin
			cfg_w_eff = WcntBits'(cfg_w_raw);
		end
		if (cfg_data[FRAME_HEIGHT_BITS-1:0] == '0) begin
			cfg_h_eff = ROW_BITS'(1);
		end else if (cfg_data[FRAME_HEIGHT_BITS-1:0] > FRAME_HEIGHT_BITS'(MAX_HEIGHT)) begin
			cfg_h_eff = ROW_BITS'(MAX_HEIGHT);
		end else begin
			cfg_h_eff = ROW_BITS'(cfg_data[FRAME_HEIGHT_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WcntBits'(ResetW);
			eff_h_q <= ROW_BITS'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  eff_w_q <= cfg_w_eff;
				REG_FRAME_HEIGHT: eff_h_q <= cfg_h_eff;
				default: ;
			endcase
		end
	end

	// Result timing, tap validity and frame end for the item being accepted.
	always_comb begin
		lag      = LeadBits'({eff_w_q, 1'b0}) + LeadBits'(2);
		res_now  = (lead_q == lag);
		col_x    = ColXBits'(out_col_q);
		w_x      = ColXBits'(eff_w_q);
		in_wrap  = (ColXBits'(in_col_q) + ColXBits'(1)) == w_x;
		out_wrap = (col_x + ColXBits'(1)) == w_x;
		last_now = out_wrap && ((out_row_q + ROW_BITS'(1)) == eff_h_q);

		mask_now.row_ok[0] = out_row_q >= ROW_BITS'(2);
		mask_now.row_ok[1] = out_row_q != '0;
		mask_now.row_ok[2] = 1'b1;
		mask_now.row_ok[3] = (out_row_q + ROW_BITS'(1)) < eff_h_q;
		mask_now.row_ok[4] = (out_row_q + ROW_BITS'(2)) < eff_h_q;
		mask_now.col_ok[0] = col_x >= ColXBits'(2);
		mask_now.col_ok[1] = col_x != '0;
		mask_now.col_ok[2] = 1'b1;
		mask_now.col_ok[3] = (col_x + ColXBits'(1)) < w_x;
		mask_now.col_ok[4] = (col_x + ColXBits'(2)) < w_x;

		px_now = drain ? '0 : PIXEL_BITS'(pixel_value);
	end

	// Frame position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			lead_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			in_col_q  <= '0;
			lead_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (in_accept) begin
			if (res_now && last_now) begin
				in_col_q  <= '0;
				lead_q    <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_wrap ? '0 : in_col_q + ColBits'(1);
				if (!res_now) begin
					lead_q <= lead_q + LeadBits'(1);
				end else if (out_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_BITS'(1);
				end else begin
					out_col_q <= out_col_q + ColBits'(1);
				end
			end
		end
	end

	// Valid bits of the pipeline; only items that produce a result go past stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			rv_s2 <= 1'b0;
			rv_s3 <= 1'b0;
			rv_s4 <= 1'b0;
			rv_s5 <= 1'b0;
			rv_s6 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_accept;
			rv_s2 <= v_s1 && res_s1;
			rv_s3 <= rv_s2;
			rv_s4 <= rv_s3;
			rv_s5 <= rv_s4;
			rv_s6 <= rv_s5;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1  <= res_now;
			last_s1 <= last_now;
			mask_s1 <= mask_now;
			px_s1   <= px_now;
			col_s1  <= in_col_q;
			last_s2 <= last_s1;
			mask_s2 <= mask_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			sum_s4  <= sum_d;
			last_s5 <= last_s4;
			last_s6 <= last_s5;
		end
	end

	// Line store: each word holds the four rows above one column, newest in lane zero.
	assign ram_we    = adv && v_s1;
	assign ram_wdata = {lanes[2], lanes[1], lanes[0], px_s1};

	gblur_ram #(
		.WIDTH (LaneBits),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (in_col_q),
		.rdata (rd_lanes)
	);

	// Forward a word written in the same cycle as its read (narrow frames).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (in_accept) begin
			byp_q <= ram_we && (col_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byp_data_q <= ram_wdata;
		end
	end

	assign lanes   = byp_q ? byp_data_q : rd_lanes;
	assign col_new = {px_s1, lanes[0], lanes[1], lanes[2], lanes[3]};

	// Row of column cells: the newest column enters the rightmost cell.
	for (genvar dc = 0; dc < TAPS; dc++) begin : g_cell
		assign cell_ctl[dc] = '{
			shift:  adv && v_s1,
			calc:   adv,
			row_ok: mask_s2.row_ok,
			col_ok: mask_s2.col_ok[dc]
		};

		if (dc == TAPS - 1) begin : g_head
			gblur_cell #(
				.PIXEL_BITS (PIXEL_BITS)
			) u_cell (
				.clk     (clk),
				.ctl     (cell_ctl[dc]),
				.weights (TAP_WEIGHT[dc]),
				.col_in  (col_new),
				.col_out (win[dc]),
				.partial (part[dc])
			);
		end else begin : g_body
			gblur_cell #(
				.PIXEL_BITS (PIXEL_BITS)
			) u_cell (
				.clk     (clk),
				.ctl     (cell_ctl[dc]),
				.weights (TAP_WEIGHT[dc]),
				.col_in  (win[dc+1]),
				.col_out (win[dc]),
				.partial (part[dc])
			);
		end
	end

	// Add the five column partial sums.
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < TAPS; i++) begin
			sum_d = sum_d + SumBits'(part[i]);
		end
	end

	gblur_div #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_div (
		.clk  (clk),
		.en   (adv),
		.sum  (sum_s4),
		.quot (quot_s6)
	);

	// Output register with a one-entry skid buffer behind it.
	assign out_take  = out_valid_q && !out_stall;
	assign load_out  = skid_valid_q ? out_take : (rv_s6 && !(out_valid_q && !out_take));
	assign load_skid = !skid_valid_q && rv_s6 && out_valid_q && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= skid_valid_q ? skid_value_q : PORT_PIXEL_BITS'(quot_s6);
			out_end_q   <= skid_valid_q ? skid_end_q : last_s6;
		end
		if (load_skid) begin
			skid_value_q <= PORT_PIXEL_BITS'(quot_s6);
			skid_end_q   <= last_s6;
		end
	end

	assign out_valid     = out_valid_q;
	assign blurred_value = out_value_q;
	assign frame_end     = out_end_q;

	// The skid buffer only fills behind a waiting output transaction.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid buffer holds a result while the output register is empty");

	// While the skid buffer is full, no result moves inside the pipeline.
	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable({v_s1, rv_s2, rv_s3, rv_s4, rv_s5, rv_s6}))
		else $error("pipeline advanced while the skid buffer was full");

	// A new output transaction only appears from a finished result.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rv_s6))
		else $error("output became valid without a result leaving the pipeline");

	// Accepting the last item of a frame restarts the frame position.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !cfg_we && res_now && last_now) |=>
		(in_col_q == '0 && lead_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("frame counters did not restart after the last result");

	// Column counters stay inside the programmed width.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WcntBits'(in_col_q) < eff_w_q) && (WcntBits'(out_col_q) < eff_w_q))
		else $error("column counter ran past the frame width");

endmodule

`default_nettype wire

>>> rtl/gblur_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
`default_nettype none

module gblur_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/gblur_cell.sv
// One window column cell: holds five pixels and forms their weighted partial sum.
`default_nettype none

module gblur_cell
	import gblur_pkg::*;
#(
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  cell_ctl_t                        ctl,
	input  weight_col_t                      weights,
	input  logic [TAPS-1:0][PIXEL_BITS-1:0]  col_in,
	output logic [TAPS-1:0][PIXEL_BITS-1:0]  col_out,
	output logic [PIXEL_BITS+6:0]            partial
);

	localparam int PartBits = PIXEL_BITS + 7;

	logic [TAPS-1:0][PIXEL_BITS-1:0] column_q;
	logic [PartBits-1:0]             part_d;
	logic [PartBits-1:0]             part_s3;

	// Column register: loads col_in (the neighbor, or the new column in the head cell) once per input transaction.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			column_q <= col_in;
		end
	end

	// Weighted sum of the taps that fall inside the frame.
	always_comb begin
		part_d = '0;
		for (int dr = 0; dr < TAPS; dr++) begin
			if (ctl.col_ok && ctl.row_ok[dr]) begin
				part_d = part_d + PartBits'(column_q[dr]) * PartBits'(weights[dr]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			part_s3 <= part_d;
		end
	end

	assign col_out = column_q;
	assign partial = part_s3;

endmodule

`default_nettype wire

>>> rtl/gblur_div.sv
// Two-stage divide by the kernel total using a reciprocal multiply and one correction.
`default_nettype none

module gblur_div
	import gblur_pkg::*;
#(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [PIXEL_BITS+8:0] sum,
	output logic [PIXEL_BITS-1:0] quot
);

	localparam int SumBits   = PIXEL_BITS + 9;
	localparam int Shift     = SumBits;
	localparam int RecipBits = SumBits - 8;
	localparam int ProdBits  = SumBits + RecipBits;
	localparam longint unsigned Recip = (64'd1 << Shift) / KERNEL_TOTAL;
	localparam logic [RecipBits-1:0] RecipConst = RecipBits'(Recip);

	logic [SumBits-1:0]    sum_s5;
	logic [ProdBits-1:0]   prod_s5;
	logic [PIXEL_BITS-1:0] quot_s6;
	logic [PIXEL_BITS-1:0] est;
	logic [SumBits-1:0]    rem_d;

	// The estimate is low by at most one; the remainder tells which.
	assign est   = PIXEL_BITS'(prod_s5 >> Shift);
	assign rem_d = sum_s5 - SumBits'(est) * SumBits'(KERNEL_TOTAL);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5  <= sum;
			prod_s5 <= sum * RecipConst;
			quot_s6 <= (rem_d >= SumBits'(KERNEL_TOTAL)) ? est + PIXEL_BITS'(1) : est;
		end
	end

	assign quot = quot_s6;

endmodule

`default_nettype wire

>>> bench/tb_gaussian_blur_5x5_unit.sv
// Self-checking testbench for the streaming 5x5 Gaussian blur unit with its own frame predictor.
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5_unit
	import gblur_pkg::*;
();

	localparam int HIST_SPAN     = 4 * 1024 + 5;
	localparam int WIDTH_CAP     = 1024;
	localparam int HEIGHT_CAP    = 4096;
	localparam int BLUR_DIVISOR  = 273;
	localparam int RESET_COLS    = 640;
	localparam int RESET_ROWS    = 480;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 100;

	typedef struct packed {
		logic [PORT_PIXEL_BITS-1:0] value;
		logic                       drain;
	} pixel_item_t;

	typedef struct packed {
		logic [PORT_PIXEL_BITS-1:0] value;
		logic                       last;
	} blur_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [PORT_PIXEL_BITS-1:0] pixel_value = '0;
	logic                       drain = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [PORT_PIXEL_BITS-1:0] blurred_value;
	logic                       frame_end;

	gaussian_blur_5x5_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_value  (pixel_value),
		.drain        (drain),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blurred_value(blurred_value),
		.frame_end    (frame_end)
	);

	// Pixels waiting to be sent and blurred pixels waiting to come out.
	pixel_item_t  pixel_feed[$];
	blur_result_t pending_blurs[$];
	pixel_item_t  feed_head;
	blur_result_t want;

	// Predictor state: pixel history, geometry registers and frame position.
	logic [PORT_PIXEL_BITS-1:0]  line_hist [HIST_SPAN];
	logic [FRAME_WIDTH_BITS-1:0] width_reg = FRAME_WIDTH_BITS'(RESET_COLS);
	logic [CFG_DATA_BITS-1:0]    height_reg = CFG_DATA_BITS'(RESET_ROWS);
	int unsigned                 frame_pos = 0;

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	bit          src_gaps_on = 1'b1;
	bit          sink_stalls_on = 1'b1;
	int          gap_left = 0;
	int          hold_left = 0;
	int          hold_req = 0;
	int          hold_done = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int active_width(logic [FRAME_WIDTH_BITS-1:0] raw);
		if (raw == 0) return 1;
		if (raw > WIDTH_CAP) return WIDTH_CAP;
		return int'(raw);
	endfunction

	function automatic int active_height(logic [CFG_DATA_BITS-1:0] raw);
		if (raw == 0) return 1;
		if (raw > HEIGHT_CAP) return HEIGHT_CAP;
		return int'(raw);
	endfunction

	// Kernel weight by tap position; the kernel is symmetric in both directions.
	function automatic int tap_weight(int dr, int dc);
		int a;
		int b;
		a = (dr > 2) ? 4 - dr : dr;
		b = (dc > 2) ? 4 - dc : dc;
		case (a * 3 + b)
			0:       return 1;
			1, 3:    return 4;
			2, 6:    return 6;
			4:       return 16;
			5, 7:    return 26;
			default: return 41;
		endcase
	endfunction

	// Stores one accepted pixel and predicts the blurred pixel that it releases, if any.
	function automatic void filter_pixel(logic [PORT_PIXEL_BITS-1:0] value, logic is_drain);
		int w;
		int h;
		int total;
		int lag;
		int n;
		int k;
		int orow;
		int ocol;
		int r;
		int c;
		int sum;
		blur_result_t res;
		w = active_width(width_reg);
		h = active_height(height_reg);
		total = w * h;
		lag = 2 * w + 2;
		n = int'(frame_pos);
		if (n < total) line_hist[n % HIST_SPAN] = is_drain ? '0 : value;
		frame_pos = n + 1;
		if (n < lag) return;
		k = n - lag;
		orow = k / w;
		ocol = k % w;
		sum = 0;
		for (int dr = 0; dr < 5; dr++) begin
			for (int dc = 0; dc < 5; dc++) begin
				r = orow + dr - 2;
				c = ocol + dc - 2;
				if (r >= 0 && r < h && c >= 0 && c < w)
					sum += int'(line_hist[(r * w + c) % HIST_SPAN]) * tap_weight(dr, dc);
			end
		end
		res.value = PORT_PIXEL_BITS'(sum / BLUR_DIVISOR);
		res.last = (k + 1 >= total);
		pending_blurs.push_back(res);
		if (res.last) frame_pos = 0;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (!src_gaps_on) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic int pick_hold();
		if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic void push_item(logic [PORT_PIXEL_BITS-1:0] v, logic d);
		pixel_item_t item;
		item.value = v;
		item.drain = d;
		pixel_feed.push_back(item);
		items_queued++;
	endfunction

	// Queues one frame at the current geometry followed by its flush items, or a cut-off
	// prefix of it. Returns the number of items queued.
	function automatic int queue_frame(bit cut_short);
		int w;
		int total;
		int span;
		int style;
		logic [PORT_PIXEL_BITS-1:0] v;
		logic d;
		w = active_width(width_reg);
		total = w * active_height(height_reg);
		span = total + 2 * w + 2;
		if (cut_short) span = $urandom_range(1, span - 1);
		style = $urandom_range(0, 5);
		for (int n = 0; n < span; n++) begin
			if (n < total) begin
				case (style)
					0:       v = '1;
					1:       v = $urandom_range(0, 1) ? '1 : '0;
					default: v = PORT_PIXEL_BITS'($urandom_range(0, 255));
				endcase
				// Now and then a drain item lands inside the frame and stands for a zero.
				d = ($urandom_range(0, 15) == 0);
			end else begin
				// Flush items, some of them plain pixels whose value is ignored.
				v = PORT_PIXEL_BITS'($urandom_range(0, 255));
				d = ($urandom_range(0, 5) != 0);
			end
			push_item(v, d);
		end
		return span;
	endfunction

	// Waits until every queued item is taken and every predicted result has come out.
	task automatic settle(int tail);
		while (items_taken != items_queued || pending_blurs.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Register write while the unit is idle; any write restarts the frame.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
		settle(SETTLE_CYCLES);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_FRAME_WIDTH) width_reg = data[FRAME_WIDTH_BITS-1:0];
		else height_reg = data;
		frame_pos = 0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Input driver: predicts on each accepted transaction, then offers the next pixel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				filter_pixel(pixel_value, drain);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pixel_feed.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					feed_head = pixel_feed.pop_front();
					pixel_value <= feed_head.value;
					drain <= feed_head.drain;
					in_valid <= 1'b1;
					gap_left = pick_gap();
				end
			end
		end
	end

	// Output monitor: checks each accepted transaction and decides the next stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_blurs.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected result, nothing expected, got value %0d end %0b",
							$time, blurred_value, frame_end);
				end else begin
					want = pending_blurs.pop_front();
					if (want.value !== blurred_value || want.last !== frame_end) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("%0t: blurred_value expected %0d got %0d, frame_end expected %0b got %0b",
								$time, want.value, blurred_value, want.last, frame_end);
					end
				end
				// A requested long hold lets the unit fill up while the sender keeps going.
				if (hold_req != hold_done) begin
					hold_done = hold_req;
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
				hold_left = pick_hold() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transaction or register write.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int rand_items;
		int kind;
		int w;
		int h;
		int spent;
		logic [CFG_DATA_BITS-1:0] wdata;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero geometry acts as a single pixel; drain inside the frame stores a zero;
		// a plain pixel after the frame counts as a flush item.
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '0);
		push_item(8'hFF, 1'b0);
		push_item(8'hAA, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'h55, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b1);
		repeat (4) push_item(8'hFF, 1'b0);

		// Width with its unused upper data bits set, two rows, mixed extremes.
		write_reg(REG_FRAME_WIDTH, 13'h1803);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b0);
		for (int i = 0; i < 8; i++) push_item(8'hFF, i[0]);

		// A long output hold in the middle of a frame, so the unit fills and stalls its input.
		write_reg(REG_FRAME_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd8);
		hold_req++;
		void'(queue_frame(1'b0));

		// Random geometries with whole frames, back-to-back frames and cut-off frames.
		hold_req++;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) w = $urandom_range(1, 8);
			else if (kind < 95) w = $urandom_range(9, 40);
			else w = $urandom_range(41, 100);
			if (w > 40) h = $urandom_range(1, 3);
			else if (w > 8) h = $urandom_range(1, 10);
			else h = $urandom_range(1, 20);
			if ($urandom_range(0, 19) == 0) w = 0;
			if ($urandom_range(0, 19) == 0) h = 0;
			wdata = {2'($urandom_range(0, 3)), 11'(w)};
			case ($urandom_range(0, 3))
				0: write_reg(REG_FRAME_WIDTH, wdata);
				1: write_reg(REG_FRAME_HEIGHT, 13'(h));
				2: begin
					write_reg(REG_FRAME_HEIGHT, 13'(h));
					write_reg(REG_FRAME_WIDTH, wdata);
				end
				default: begin
					write_reg(REG_FRAME_WIDTH, wdata);
					write_reg(REG_FRAME_HEIGHT, 13'(h));
				end
			endcase
			src_gaps_on = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			spent = queue_frame(1'b0);
			if ($urandom_range(0, 1) == 0 && rand_items + spent < RANDOM_ITEMS)
				spent += queue_frame(1'b0);
			if ($urandom_range(0, 5) == 0 && rand_items + spent < RANDOM_ITEMS)
				spent += queue_frame(1'b1);
			rand_items += spent;
		end

		settle(20);
		if (error_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

>>> gaussian_blur_5x5_unit.f
rtl/gblur_pkg.sv
rtl/gblur_ram.sv
rtl/gblur_cell.sv
rtl/gblur_div.sv
rtl/gaussian_blur_5x5_unit.sv
bench/tb_gaussian_blur_5x5_unit.sv
